// ----- rtl/rgbled_pkg.sv -----
package rgbled_pkg;

  localparam int MAX_PIXELS = 16;
  localparam int PIX_AW     = 4;
  localparam int CNT_W      = 5;
  localparam int WORD_W     = 24;

  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_START = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [2:0] REG_LED_COUNT  = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [2:0] REG_ONE_LOW    = 3'd2;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW   = 3'd4;
  localparam logic [2:0] REG_LATCH_GAP  = 3'd5;

  typedef struct packed {
    logic [9:0]  one_high;
    logic [9:0]  one_low;
    logic [9:0]  zero_high;
    logic [9:0]  zero_low;
    logic [15:0] latch_gap;
  } timing_t;

  typedef struct packed {
    logic idle;
    logic line_next;
    logic busy_next;
  } ser_stat_t;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    at_least_one = (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

// ----- rtl/rgbled_pixel_mem.sv -----
module rgbled_pixel_mem (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [rgbled_pkg::PIX_AW-1:0]     wr_addr,
  input  logic [rgbled_pkg::WORD_W-1:0]     wr_data,
  input  logic                              clr_en,
  input  logic [rgbled_pkg::CNT_W-1:0]      clr_count,
  input  logic                              rd_en,
  input  logic [rgbled_pkg::PIX_AW-1:0]     rd_addr,
  output logic [rgbled_pkg::WORD_W-1:0]     rd_word,
  input  logic [rgbled_pkg::PIX_AW-1:0]     pf_addr,
  output logic [rgbled_pkg::WORD_W-1:0]     pf_word
);
  import rgbled_pkg::*;

  logic [WORD_W-1:0] mem [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] valid;
  logic [WORD_W-1:0] rd_data;
  logic              rd_vld;
  logic [WORD_W-1:0] pf_data;
  logic [PIX_AW-1:0] pf_addr_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= valid[rd_addr];
    end
    if (wr_en && (wr_addr == pf_addr)) begin
      pf_data <= wr_data;
    end else begin
      pf_data <= mem[pf_addr];
    end
    pf_addr_q <= pf_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < MAX_PIXELS; i++) begin
        if (clr_en && (CNT_W'(i) < clr_count)) begin
          valid[i] <= 1'b0;
        end
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_word = rd_vld ? rd_data : '0;
  assign pf_word = valid[pf_addr_q] ? pf_data : '0;

endmodule

// ----- rtl/rgbled_serializer.sv -----
module rgbled_serializer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              tick,
  input  logic [rgbled_pkg::CNT_W-1:0]      count,
  input  rgbled_pkg::timing_t               timing,
  input  logic [rgbled_pkg::WORD_W-1:0]     pf_word,
  output logic [rgbled_pkg::PIX_AW-1:0]     pf_addr,
  output rgbled_pkg::ser_stat_t             stat
);
  import rgbled_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  logic [1:0]        phase, phase_next;
  logic [15:0]       cnt, cnt_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic [4:0]        bit_ptr, bit_next;
  logic [WORD_W-1:0] cur_word, word_next;

  logic              cur_bit;
  logic [15:0]       cnt_dec;
  logic [4:0]        bit_inc;
  logic              pix_end;
  logic [CNT_W-1:0]  new_ptr;
  logic [4:0]        new_bit;
  logic [WORD_W-1:0] new_word;
  logic              new_b;

  always_comb begin
    cur_bit  = cur_word[5'd23 - bit_ptr];
    cnt_dec  = cnt - 16'd1;
    bit_inc  = bit_ptr + 5'd1;
    pix_end  = (bit_inc == 5'd24);
    new_ptr  = pix_end ? ptr + CNT_W'(1) : ptr;
    new_bit  = pix_end ? 5'd0 : bit_inc;
    new_word = pix_end ? pf_word : cur_word;
    new_b    = new_word[5'd23 - new_bit];

    phase_next = phase;
    cnt_next   = cnt;
    ptr_next   = ptr;
    bit_next   = bit_ptr;
    word_next  = cur_word;

    if (start) begin
      ptr_next  = '0;
      bit_next  = '0;
      word_next = pf_word;
      if (count == '0) begin
        phase_next = PH_GAP;
        cnt_next   = at_least_one(timing.latch_gap);
      end else begin
        phase_next = PH_HIGH;
        cnt_next   = at_least_one(pf_word[WORD_W-1] ? 16'(timing.one_high)
                                                    : 16'(timing.zero_high));
      end
    end else if (tick && (phase != PH_IDLE)) begin
      cnt_next = cnt_dec;
      if (cnt_dec == 16'd0) begin
        case (phase)
          PH_HIGH: begin
            phase_next = PH_LOW;
            cnt_next   = at_least_one(cur_bit ? 16'(timing.one_low)
                                              : 16'(timing.zero_low));
          end
          PH_LOW: begin
            ptr_next  = new_ptr;
            bit_next  = new_bit;
            word_next = new_word;
            if (new_ptr >= count) begin
              phase_next = PH_GAP;
              cnt_next   = at_least_one(timing.latch_gap);
            end else begin
              phase_next = PH_HIGH;
              cnt_next   = at_least_one(new_b ? 16'(timing.one_high)
                                              : 16'(timing.zero_high));
            end
          end
          default: begin
            phase_next = PH_IDLE;
            ptr_next   = '0;
            bit_next   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      cnt     <= '0;
      ptr     <= '0;
      bit_ptr <= '0;
    end else begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      ptr     <= ptr_next;
      bit_ptr <= bit_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_word <= word_next;
  end

  // prefetch the pixel that follows the one on the line; pixel 0 while idle or in the gap
  assign pf_addr = ((phase == PH_IDLE) || (phase == PH_GAP)) ? '0
                                                             : ptr[PIX_AW-1:0] + PIX_AW'(1);

  assign stat.idle      = (phase == PH_IDLE);
  assign stat.line_next = (phase_next == PH_HIGH);
  assign stat.busy_next = (phase_next != PH_IDLE);

endmodule

// ----- rtl/addressable_rgb_led_driver.sv -----
// The result of an item is registered and is on m_tdata in the cycle after its transaction.
// Throughput: one item per cycle while m_tready is high; a result waiting on
// m_tready holds s_tready low until it is taken.
// A pixel read returns its data from a registered memory port; the serializer
// prefetches the next pixel from a second read port.
// Reset (synchronous, rst high): idle, line low, registers at their defaults,
// every pixel reads as zero until it is set.
module addressable_rgb_led_driver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // led_index[3:0], red[11:4], green[19:12], blue[27:20]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // line[0], busy_res[1], red_read[9:2], green_read[17:10],
                                 // blue_read[25:18]
  output logic [0:0]  m_tuser,   // read_ok[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rgbled_pkg::*;

  logic [CNT_W-1:0]  led_count;
  timing_t           timing;
  logic [CNT_W-1:0]  count;
  logic [2:0]        reg_sel;
  logic              cfg_wr;

  logic              in_acc;
  logic [2:0]        cmd;
  logic [PIX_AW-1:0] led_index;
  logic [7:0]        red, green, blue;
  logic              idx_ok;

  logic              do_set, do_read, do_clear, do_start, do_tick;
  logic [WORD_W-1:0] rd_word;
  logic [PIX_AW-1:0] pf_addr;
  logic [WORD_W-1:0] pf_word;
  ser_stat_t         stat;

  logic              out_valid;
  logic              out_line;
  logic              out_busy;
  logic              out_ok;
  logic [WORD_W-1:0] out_word;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count        <= CNT_W'(16);
      timing.one_high  <= 10'd81;
      timing.one_low   <= 10'd40;
      timing.zero_high <= 10'd41;
      timing.zero_low  <= 10'd79;
      timing.latch_gap <= 16'd7200;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_LED_COUNT: led_count        <= pwdata[CNT_W-1:0];
        REG_ONE_HIGH:  timing.one_high  <= pwdata[9:0];
        REG_ONE_LOW:   timing.one_low   <= pwdata[9:0];
        REG_ZERO_HIGH: timing.zero_high <= pwdata[9:0];
        REG_ZERO_LOW:  timing.zero_low  <= pwdata[9:0];
        REG_LATCH_GAP: timing.latch_gap <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LED_COUNT: prdata = 32'(led_count);
      REG_ONE_HIGH:  prdata = 32'(timing.one_high);
      REG_ONE_LOW:   prdata = 32'(timing.one_low);
      REG_ZERO_HIGH: prdata = 32'(timing.zero_high);
      REG_ZERO_LOW:  prdata = 32'(timing.zero_low);
      REG_LATCH_GAP: prdata = 32'(timing.latch_gap);
      default:       prdata = '0;
    endcase
  end

  assign count = (led_count > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : led_count;

  assign s_tready  = !out_valid || m_tready;
  assign in_acc    = s_tvalid && s_tready;
  assign cmd       = s_tuser;
  assign led_index = s_tdata[3:0];
  assign red       = s_tdata[11:4];
  assign green     = s_tdata[19:12];
  assign blue      = s_tdata[27:20];
  assign idx_ok    = CNT_W'(led_index) < count;

  assign do_tick  = in_acc && (cmd == CMD_TICK);
  assign do_set   = in_acc && stat.idle && (cmd == CMD_SET) && idx_ok;
  assign do_read  = in_acc && stat.idle && (cmd == CMD_READ) && idx_ok;
  assign do_clear = in_acc && stat.idle && (cmd == CMD_CLEAR);
  assign do_start = in_acc && stat.idle && (cmd == CMD_START);

  rgbled_pixel_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (do_set),
    .wr_addr   (led_index),
    .wr_data   ({green, red, blue}),
    .clr_en    (do_clear),
    .clr_count (count),
    .rd_en     (in_acc),
    .rd_addr   (led_index),
    .rd_word   (rd_word),
    .pf_addr   (pf_addr),
    .pf_word   (pf_word)
  );

  rgbled_serializer u_ser (
    .clk     (clk),
    .rst     (rst),
    .start   (do_start),
    .tick    (do_tick),
    .count   (count),
    .timing  (timing),
    .pf_word (pf_word),
    .pf_addr (pf_addr),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_line <= stat.line_next;
      out_busy <= stat.busy_next;
      out_ok   <= do_read;
    end
  end

  assign out_word = out_ok ? rd_word : '0;

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_word[7:0], out_word[23:16], out_word[15:8], out_busy, out_line};
  assign m_tuser  = out_ok;

endmodule
